>>> hw/rtl/sftd_pkg.sv
// Package: shared types, constants and helpers of the sensor FIFO tag decoder.
package sftd_pkg;

    localparam int TagW      = 5;
    localparam int PayloadW  = 48;
    localparam int KindW     = 3;
    localparam int QW        = 16;
    localparam int WW        = 15;
    localparam int PresW     = 23;
    localparam int MagW      = 20;
    localparam int TempW     = 16;
    localparam int CfgIdxW   = 2;
    localparam int CfgDataW  = 5;
    // Square root: one result bit per cell, 15 result bits.
    localparam int SqrtCells = 15;
    localparam int RemW      = 30;

    localparam logic [KindW-1:0] KIND_NONE = 3'd0;
    localparam logic [KindW-1:0] KIND_ROT  = 3'd1;
    localparam logic [KindW-1:0] KIND_PRES = 3'd2;
    localparam logic [KindW-1:0] KIND_MAG  = 3'd3;
    localparam logic [KindW-1:0] KIND_TEMP = 3'd4;

    localparam logic [CfgIdxW-1:0] REG_ROT  = 2'd0;
    localparam logic [CfgIdxW-1:0] REG_PRES = 2'd1;
    localparam logic [CfgIdxW-1:0] REG_MAG  = 2'd2;
    localparam logic [CfgIdxW-1:0] REG_TEMP = 2'd3;

    // Decoded fields other than w, carried alongside the square root chain.
    typedef struct packed {
        logic [KindW-1:0]        kind;
        logic signed [QW-1:0]    qx;
        logic signed [QW-1:0]    qy;
        logic signed [QW-1:0]    qz;
        logic [PresW-1:0]        pres;
        logic signed [MagW-1:0]  mx;
        logic signed [MagW-1:0]  my;
        logic signed [MagW-1:0]  mz;
        logic signed [TempW-1:0] temp;
    } side_t;

    // State passed from one root cell to the next.
    typedef struct packed {
        logic              valid;
        logic [RemW-1:0]   rem;
        logic [WW-1:0]     root;
        side_t             side;
    } link_t;

    // Half float to signed Q2.14, truncated toward zero, saturated.
    function automatic logic signed [QW-1:0] half_to_q14(input logic [15:0] h);
        logic        neg;
        logic [4:0]  e;
        logic [10:0] sig;
        logic [29:0] mag;
        logic [15:0] res;
        neg = h[15];
        e   = h[14:10];
        sig = {1'b1, h[9:0]};
        mag = '0;
        if (e >= 5'd11)
            mag = {19'd0, sig} << (e - 5'd11);
        else if (e != 5'd0)
            mag = {19'd0, sig >> (5'd11 - e)};
        if (e == 5'h1F)
            res = neg ? 16'h8000 : 16'h7FFF;
        else if (neg)
            res = (mag > 30'd32768) ? 16'h8000 : 16'(-mag[15:0]);
        else
            res = (mag > 30'd32767) ? 16'h7FFF : mag[15:0];
        return res;
    endfunction

endpackage

>>> hw/rtl/sensor_fifo_tag_decoder.sv
// Top level: sensor FIFO word decoder with a chain of square root cells.
//
// Usage: write tag registers on cfg_we/cfg_index/cfg_data while idle. Pulse
// start with word_tag and payload; a word is taken whenever start is high
// (busy is always low), so a transfer may come in every cycle.
// Each word gives one result, shown for one cycle with done high.
// From start to done a word passes these register stages: one decodes the
// halves, one squares, one sums and forms 1 - S, then 15 root cells each
// resolve one bit of w. Throughput is one word per cycle.
// Other kinds travel through the same chain so results stay in order.
// Reset clears valid bits and sets the tag registers to 19, 14, 15, 16.
// The receiver cannot stall; done is a one-cycle strobe.
module sensor_fifo_tag_decoder
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [sftd_pkg::CfgIdxW-1:0]        cfg_index,
    input  logic [sftd_pkg::CfgDataW-1:0]       cfg_data,
    input  logic                                start,
    output logic                                busy,
    input  logic [sftd_pkg::TagW-1:0]           word_tag,
    input  logic [sftd_pkg::PayloadW-1:0]       payload,
    output logic                                done,
    output logic [sftd_pkg::KindW-1:0]          kind,
    output logic [sftd_pkg::WW-1:0]             quat_w,
    output logic signed [sftd_pkg::QW-1:0]      quat_x,
    output logic signed [sftd_pkg::QW-1:0]      quat_y,
    output logic signed [sftd_pkg::QW-1:0]      quat_z,
    output logic [sftd_pkg::PresW-1:0]          pressure_pa_x16,
    output logic signed [sftd_pkg::MagW-1:0]    magnet_x,
    output logic signed [sftd_pkg::MagW-1:0]    magnet_y,
    output logic signed [sftd_pkg::MagW-1:0]    magnet_z,
    output logic signed [sftd_pkg::TempW-1:0]   temp_centi_c
);
    import sftd_pkg::*;

    logic [TagW-1:0] rot_tag_reg, pres_tag_reg, mag_tag_reg, temp_tag_reg;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rot_tag_reg  <= 5'd19;
            pres_tag_reg <= 5'd14;
            mag_tag_reg  <= 5'd15;
            temp_tag_reg <= 5'd16;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ROT:  rot_tag_reg  <= cfg_data;
                REG_PRES: pres_tag_reg <= cfg_data;
                REG_MAG:  mag_tag_reg  <= cfg_data;
                REG_TEMP: temp_tag_reg <= cfg_data;
                default:  ;
            endcase
        end
    end

    assign busy = 1'b0;

    // Stage 1: decode by tag, first match wins.
    side_t side_next, s1_side_reg, s2_side_reg, s3_side_reg;
    logic  s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic [PresW+7:0] pres_prod;

    always_comb
    begin
        side_next = '0;
        pres_prod = 31'(payload[23:0]) * 31'd100;
        if (word_tag == rot_tag_reg)
        begin
            side_next.kind = KIND_ROT;
            side_next.qx   = half_to_q14(payload[15:0]);
            side_next.qy   = half_to_q14(payload[31:16]);
            side_next.qz   = half_to_q14(payload[47:32]);
        end
        else if (word_tag == pres_tag_reg)
        begin
            side_next.kind = KIND_PRES;
            side_next.pres = pres_prod[PresW+7:8];
        end
        else if (word_tag == mag_tag_reg)
        begin
            side_next.kind = KIND_MAG;
            side_next.mx   = MagW'($signed(payload[15:0])) * 20'sd15;
            side_next.my   = MagW'($signed(payload[31:16])) * 20'sd15;
            side_next.mz   = MagW'($signed(payload[47:32])) * 20'sd15;
        end
        else if (word_tag == temp_tag_reg)
        begin
            side_next.kind = KIND_TEMP;
            side_next.temp = payload[15:0];
        end
    end

    // Stage 2: squares; stage 3: sum and 1 - S.
    logic [RemW:0] sqx_reg, sqy_reg, sqz_reg;
    logic [RemW+2:0] sum;
    logic [RemW-1:0] rem_reg;
    logic [RemW-1:0] rem_next;

    always_comb
    begin
        sum = 33'(sqx_reg) + 33'(sqy_reg) + 33'(sqz_reg);
        rem_next = (sum >= 33'h1000_0000) ? '0 : RemW'(33'h1000_0000 - sum);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= start;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_side_reg <= side_next;
        s2_side_reg <= s1_side_reg;
        s3_side_reg <= s2_side_reg;
        sqx_reg     <= 31'(32'(s1_side_reg.qx) * 32'(s1_side_reg.qx));
        sqy_reg     <= 31'(32'(s1_side_reg.qy) * 32'(s1_side_reg.qy));
        sqz_reg     <= 31'(32'(s1_side_reg.qz) * 32'(s1_side_reg.qz));
        rem_reg     <= rem_next;
    end

    // Root chain: cell k resolves bit 14-k.
    link_t chain [SqrtCells+1];

    always_comb
    begin
        chain[0].valid = s3_valid_reg;
        chain[0].rem   = rem_reg;
        chain[0].root  = '0;
        chain[0].side  = s3_side_reg;
    end

    for (genvar k = 0; k < SqrtCells; k++)
    begin : g_cell
        sftd_root_cell u_cell
        (
            .clk     (clk),
            .rst_n   (rst_n),
            .bit_pos (4'(SqrtCells - 1 - k)),
            .link_in (chain[k]),
            .link_out(chain[k+1])
        );
    end

    // Drive results; fields outside the decoded kind stay zero.
    always_comb
    begin
        done            = chain[SqrtCells].valid;
        kind            = chain[SqrtCells].side.kind;
        quat_w          = (kind == KIND_ROT) ? chain[SqrtCells].root : '0;
        quat_x          = chain[SqrtCells].side.qx;
        quat_y          = chain[SqrtCells].side.qy;
        quat_z          = chain[SqrtCells].side.qz;
        pressure_pa_x16 = chain[SqrtCells].side.pres;
        magnet_x        = chain[SqrtCells].side.mx;
        magnet_y        = chain[SqrtCells].side.my;
        magnet_z        = chain[SqrtCells].side.mz;
        temp_centi_c    = chain[SqrtCells].side.temp;
    end

    a_root_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> quat_w <= 15'd16384) else $error("w above one");
    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(s3_valid_reg, SqrtCells)) else $error("stray done");
    a_nonrot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && kind != KIND_ROT) |-> (quat_x == '0 && quat_w == '0))
        else $error("rotation fields leak");

endmodule

>>> hw/rtl/sftd_root_cell.sv
// Module: one cell of the square root chain, resolving one result bit.
module sftd_root_cell
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [3:0]         bit_pos,
    input  sftd_pkg::link_t    link_in,
    output sftd_pkg::link_t    link_out
);
    import sftd_pkg::*;

    logic [RemW-1:0] trial;
    logic [RemW-1:0] cand;
    logic            valid_reg;
    link_t           data_reg;
    link_t           data_next;

    // Trial value (2*root + 2^bit_pos) shifted to the current bit weight.
    always_comb
    begin
        trial = ({{(RemW-WW){1'b0}}, link_in.root} << (bit_pos + 4'd1))
              | ({{(RemW-1){1'b0}}, 1'b1} << {bit_pos, 1'b0});
        cand  = link_in.rem - trial;
        data_next = link_in;
        if (link_in.rem >= trial)
        begin
            data_next.rem  = cand;
            data_next.root = link_in.root | (WW'(1) << bit_pos);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= link_in.valid;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    always_comb
    begin
        link_out       = data_reg;
        link_out.valid = valid_reg;
    end

endmodule

>>> test/sftd_checker.sv
// Checker for the sensor FIFO tag decoder: config shadow, predictor and scoreboard.
`timescale 1ns / 100ps

module sftd_checker
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [sftd_pkg::CfgIdxW-1:0]      cfg_index,
    input  logic [sftd_pkg::CfgDataW-1:0]     cfg_data,
    input  logic                              start,
    input  logic                              busy,
    input  logic [sftd_pkg::TagW-1:0]         word_tag,
    input  logic [sftd_pkg::PayloadW-1:0]     payload,
    input  logic                              done,
    input  logic [sftd_pkg::KindW-1:0]        kind,
    input  logic [sftd_pkg::WW-1:0]           quat_w,
    input  logic signed [sftd_pkg::QW-1:0]    quat_x,
    input  logic signed [sftd_pkg::QW-1:0]    quat_y,
    input  logic signed [sftd_pkg::QW-1:0]    quat_z,
    input  logic [sftd_pkg::PresW-1:0]        pressure_pa_x16,
    input  logic signed [sftd_pkg::MagW-1:0]  magnet_x,
    input  logic signed [sftd_pkg::MagW-1:0]  magnet_y,
    input  logic signed [sftd_pkg::MagW-1:0]  magnet_z,
    input  logic signed [sftd_pkg::TempW-1:0] temp_centi_c,
    output int                                fail_count,
    output int                                words_pending,
    output int                                words_checked
);
    import sftd_pkg::*;

    typedef struct packed {
        logic [KindW-1:0]        kind;
        logic [WW-1:0]           w;
        logic signed [QW-1:0]    x;
        logic signed [QW-1:0]    y;
        logic signed [QW-1:0]    z;
        logic [PresW-1:0]        pres;
        logic signed [MagW-1:0]  mx;
        logic signed [MagW-1:0]  my;
        logic signed [MagW-1:0]  mz;
        logic signed [TempW-1:0] temp;
    } decoded_t;

    logic [TagW-1:0] rot_tag, pres_tag, mag_tag, temp_tag;
    decoded_t        decoded_q[$];

    function automatic int half_to_fixed(input logic [15:0] h);
        longint mag;
        if (h[14:10] == 5'h1F)
            return h[15] ? -32768 : 32767;
        if (h[14:10] == 5'd0)
            return 0;
        mag = (longint'(1024 + h[9:0]) << h[14:10]) >> 11;
        if (h[15])
            return (mag > 32768) ? -32768 : -int'(mag);
        return (mag > 32767) ? 32767 : int'(mag);
    endfunction

    function automatic int floor_root(input longint n);
        longint r;
        r = 0;
        for (int b = 15; b >= 0; b--)
            if ((r + (longint'(1) << b)) * (r + (longint'(1) << b)) <= n)
                r = r + (longint'(1) << b);
        return int'(r);
    endfunction

    function automatic decoded_t decode_word(input logic [TagW-1:0] tag,
                                             input logic [PayloadW-1:0] p);
        decoded_t d;
        int       x, y, z;
        longint   s;
        d = '0;
        if (tag == rot_tag) begin
            x = half_to_fixed(p[15:0]);
            y = half_to_fixed(p[31:16]);
            z = half_to_fixed(p[47:32]);
            s = longint'(x) * x + longint'(y) * y + longint'(z) * z;
            d.kind = KIND_ROT;
            d.w    = (s < (longint'(1) << 28)) ? WW'(floor_root((longint'(1) << 28) - s)) : '0;
            d.x    = QW'(x);
            d.y    = QW'(y);
            d.z    = QW'(z);
        end else if (tag == pres_tag) begin
            d.kind = KIND_PRES;
            d.pres = PresW'((longint'(p[23:0]) * 100) >> 8);
        end else if (tag == mag_tag) begin
            d.kind = KIND_MAG;
            d.mx   = MagW'(int'($signed(p[15:0])) * 15);
            d.my   = MagW'(int'($signed(p[31:16])) * 15);
            d.mz   = MagW'(int'($signed(p[47:32])) * 15);
        end else if (tag == temp_tag) begin
            d.kind = KIND_TEMP;
            d.temp = $signed(p[15:0]);
        end
        return d;
    endfunction

    assign words_pending = decoded_q.size();

    // Track register writes, queue a prediction per transfer, check per strobe.
    always @(posedge clk or negedge rst_n)
    begin
        decoded_t got, want;
        if (!rst_n)
        begin
            rot_tag       <= 5'd19;
            pres_tag      <= 5'd14;
            mag_tag       <= 5'd15;
            temp_tag      <= 5'd16;
            fail_count    <= 0;
            words_checked <= 0;
            decoded_q.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_ROT:  rot_tag  <= cfg_data;
                    REG_PRES: pres_tag <= cfg_data;
                    REG_MAG:  mag_tag  <= cfg_data;
                    REG_TEMP: temp_tag <= cfg_data;
                    default: ;
                endcase
            end
            if (start && !busy)
                decoded_q.push_back(decode_word(word_tag, payload));
            if (done)
            begin
                got = '{kind, quat_w, quat_x, quat_y, quat_z, pressure_pa_x16,
                        magnet_x, magnet_y, magnet_z, temp_centi_c};
                if (decoded_q.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("unexpected result: %p", got);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = decoded_q.pop_front();
                    words_checked <= words_checked + 1;
                    if (got !== want)
                    begin
                        if (fail_count < 10)
                            $display("mismatch\n  expected %p\n  actual   %p", want, got);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

>>> test/tb_sensor_fifo_tag_decoder.sv
// Testbench top: stimulus, register phases and verdict for the tag decoder.
`timescale 1ns / 100ps

module tb_sensor_fifo_tag_decoder;
    import sftd_pkg::*;

    localparam int CycleLimit = 200000;
    localparam int DrainWait  = 25;     // longer than the pipeline latency

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CfgIdxW-1:0] cfg_index = '0;
    logic [CfgDataW-1:0] cfg_data = '0;
    logic start = 1'b0;
    logic [TagW-1:0] word_tag = '0;
    logic [PayloadW-1:0] payload = '0;
    logic busy, done;
    logic [KindW-1:0] kind;
    logic [WW-1:0] quat_w;
    logic signed [QW-1:0] quat_x, quat_y, quat_z;
    logic [PresW-1:0] pressure_pa_x16;
    logic signed [MagW-1:0] magnet_x, magnet_y, magnet_z;
    logic signed [TempW-1:0] temp_centi_c;
    int fail_count, words_pending, words_checked;
    int cycles = 0;
    int sent = 0;
    int phases = 0;
    // Current tag settings, so the random part can aim at decoded kinds.
    logic [TagW-1:0] tags [4] = '{5'd19, 5'd14, 5'd15, 5'd16};

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    sensor_fifo_tag_decoder dut (.*);

    sftd_checker checker_i (.*);

    // Abort a hung run.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit)
        begin
            $display("[sensor_fifo_tag_decoder] ERROR");
            $finish;
        end
    end

    // Hold start low for the gap, then present one word until it transfers.
    task automatic send_word(input logic [TagW-1:0] tag, input logic [PayloadW-1:0] p,
                             input int gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start    <= 1'b1;
        word_tag <= tag;
        payload  <= p;
        do @(posedge clk); while (busy);
        sent++;
    endtask

    // Mostly back to back, sometimes short pauses, rarely long ones.
    function automatic int pick_gap(input bit burst);
        int r;
        if (burst)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Random half: often a moderate exponent so w comes out nonzero.
    function automatic logic [15:0] pick_half();
        logic [15:0] h;
        h = 16'($urandom);
        if ($urandom_range(0, 2) != 0)
            h[14:10] = 5'($urandom_range(8, 14));
        return h;
    endfunction

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (words_pending != 0) @(posedge clk);
        repeat (DrainWait) @(posedge clk);
    endtask

    // Write all four tag registers while the pipe is empty.
    task automatic set_tags(input logic [TagW-1:0] r, input logic [TagW-1:0] p,
                            input logic [TagW-1:0] m, input logic [TagW-1:0] t);
        logic [TagW-1:0] vals [4];
        logic [CfgIdxW-1:0] idx [4];
        vals = '{r, p, m, t};
        idx  = '{REG_ROT, REG_PRES, REG_MAG, REG_TEMP};
        drain();
        for (int i = 0; i < 4; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= vals[i];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        tags = vals;
        phases++;
    endtask

    task automatic random_words(input int count);
        int burst_left;
        logic [TagW-1:0] tag;
        logic [PayloadW-1:0] p;
        burst_left = 0;
        for (int n = 0; n < count; n++)
        begin
            if (burst_left == 0 && $urandom_range(0, 40) == 0)
                burst_left = $urandom_range(20, 40);
            if ($urandom_range(0, 9) < 8)
                tag = tags[$urandom_range(0, 3)];
            else
                tag = 5'($urandom);
            p = {$urandom, $urandom};
            if (tag == tags[0] && $urandom_range(0, 3) != 0)
                p = {pick_half(), pick_half(), pick_half()};
            send_word(tag, p, pick_gap(burst_left != 0));
            if (burst_left != 0)
                burst_left--;
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words under reset tags: rotation corner cases first.
        send_word(5'd19, 48'h0, 0);                    // all zero, w = 1.0
        send_word(5'd19, 48'h0000_0000_3C00, 0);       // x = 1.0, w = 0
        send_word(5'd19, 48'h3800_3800_3800, 1);       // 0.5 each
        send_word(5'd19, 48'hFC00_7C00_7E00, 0);       // -inf, +inf, NaN
        send_word(5'd19, 48'hFE01_FBFF_7BFF, 0);       // -NaN, -max, +max
        send_word(5'd19, 48'h8000_83FF_0001, 2);       // -0, subnormals
        send_word(5'd19, 48'h0400_8400_2C00, 0);       // smallest normals, 0.0625
        send_word(5'd19, 48'h3BFF_BBFF_4000, 0);       // just under 1, 2.0
        send_word(5'd19, 48'hFFFF_FFFF_FFFF, 0);
        send_word(5'd14, 48'h0, 0);
        send_word(5'd14, 48'hFFFF_FFFF_FFFF, 0);       // pressure max
        send_word(5'd14, 48'h0000_0000_0100, 3);
        send_word(5'd15, 48'h8000_7FFF_0000, 0);       // magnet extremes
        send_word(5'd15, 48'hFFFF_0001_8000, 0);
        send_word(5'd16, 48'hFFFF_FFFF_8000, 0);       // temperature extremes
        send_word(5'd16, 48'h0000_0000_7FFF, 0);
        send_word(5'd0, 48'hFFFF_FFFF_FFFF, 0);        // unknown tags
        send_word(5'd31, 48'h1234_5678_9ABC, 1);
        random_words(100);

        // Extreme tag values.
        set_tags(5'd0, 5'd31, 5'd1, 5'd30);
        send_word(5'd0, 48'h3800_0000_3800, 0);
        send_word(5'd31, 48'hFFFF_FFFF_FFFF, 0);
        send_word(5'd19, 48'h3C00_3C00_3C00, 0);       // old rotation tag, now unknown
        random_words(100);

        // All equal: rotation wins.
        set_tags(5'd7, 5'd7, 5'd7, 5'd7);
        random_words(50);

        // Pressure, magnet, temperature equal: pressure wins.
        set_tags(5'd31, 5'd0, 5'd0, 5'd0);
        random_words(50);

        set_tags(5'($urandom), 5'($urandom), 5'($urandom), 5'($urandom));
        random_words(100);

        drain();
        $display("%0d words sent, %0d results checked, %0d tag settings after reset",
                 sent, words_checked, phases);
        if (fail_count == 0 && words_pending == 0)
            $display("[sensor_fifo_tag_decoder] OK");
        else
            $display("[sensor_fifo_tag_decoder] ERROR");
        $finish;
    end

endmodule
